### rtl/lockset_race_detector_defines.svh
// ============================================================================
// Lockset race detector assertion macros
// Shared assertion helpers for the detector RTL. Each macro checks a property
// on the rising edge of i_clk and is disabled while i_rst_n is low.
// ============================================================================
`ifndef LOCKSET_RACE_DETECTOR_DEFINES_SVH
`define LOCKSET_RACE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LRD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lockset race detector: same-cycle check failed");

// Next-cycle implication.
`define LRD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lockset race detector: next-cycle check failed");

`else

`define LRD_ASSERT_IMP(label, ante, cons)
`define LRD_ASSERT_NXT(label, ante, cons)

`endif

`endif

### rtl/lrd_pkg.sv
// ============================================================================
// Lockset race detector package
// Operation codes, word states, field layout and default sizes shared by the
// detector modules.
// ============================================================================
package lrd_pkg;

    // Default sizes for the top-level parameters.
    localparam int SHADOW_WORDS_DEF = 16384;
    localparam int THREADS_DEF      = 16;
    localparam int LOCK_SLOTS_DEF   = 8;

    // Word index range covered by a 16-bit byte address.
    localparam int WORD_ADDR_W = 14;
    localparam int WORD_SPAN   = 16384;

    // Largest access size honored; larger sizes are clipped to it.
    localparam logic [3:0] MAX_ACCESS_SIZE = 4'd10;

    // Operation codes carried in the input tuser.
    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_WRITE       = 3'd1;
    localparam logic [2:0] OP_LOCK        = 3'd2;
    localparam logic [2:0] OP_UNLOCK      = 3'd3;
    localparam logic [2:0] OP_INIT_VIRGIN = 3'd4;
    localparam logic [2:0] OP_INIT_OWNED  = 3'd5;

    // Shadow word states.
    localparam logic [1:0] WS_VIRGIN = 2'd0;
    localparam logic [1:0] WS_EXCL   = 2'd1;
    localparam logic [1:0] WS_SHAR   = 2'd2;
    localparam logic [1:0] WS_SHMOD  = 2'd3;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // Request to the lockset memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ls_ctrl;

endpackage

### rtl/lrd_lockset_ram.sv
// ============================================================================
// Lockset memory
// Holds the set of locks each thread currently owns. One synchronous port
// with registered read data; a per-entry valid bit makes never-written
// entries read as the empty set after reset.
// ============================================================================
module lrd_lockset_ram #(
    parameter int THREADS    = lrd_pkg::THREADS_DEF,
    parameter int LOCK_SLOTS = lrd_pkg::LOCK_SLOTS_DEF,
    localparam int TID_W     = $clog2(THREADS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrd_pkg::t_ls_ctrl     i_ctrl,
    input  logic [TID_W-1:0]      i_addr,
    input  logic [LOCK_SLOTS-1:0] i_wr_data,
    output logic [LOCK_SLOTS-1:0] o_rd_data
);

    logic [LOCK_SLOTS-1:0] r_mem [THREADS];
    logic [THREADS-1:0]    r_valid;
    logic [LOCK_SLOTS-1:0] r_rd_data;
    logic                  r_rd_valid;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // Valid bits are cleared by reset and set by the first write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    // An entry never written reads as the empty lockset.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### rtl/lockset_race_detector.sv
// ============================================================================
// Lockset race detector
// Per-word lockset race detection over a flat shadow memory.
// ============================================================================
// After reset the block runs a clearing pass that sets every shadow word to
// virgin; no item is accepted until it is done. Then one item is handled at
// a time. Lock and unlock read the lockset memory when the item is taken and
// write it back in ST_LOCK, and give no result. Reads, writes and the two
// init operations touch n shadow words (1 to 4; always 1 for init): the
// transfer is taken in ST_IDLE, the word index is reduced modulo SHADOW_WORDS
// in ST_DIV1 and ST_DIV2, then ST_WORD handles one word per cycle while the
// output is free. Each word gives one result transfer; a stalled output holds
// the word loop.
// ============================================================================
`include "lockset_race_detector_defines.svh"

module lockset_race_detector #(
    parameter int SHADOW_WORDS = lrd_pkg::SHADOW_WORDS_DEF,
    parameter int THREADS      = lrd_pkg::THREADS_DEF,
    parameter int LOCK_SLOTS   = lrd_pkg::LOCK_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // thread_id[3:0], byte_address[19:4], access_size[23:20], lock_slot[26:24]
    input  logic [lrd_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation[2:0]
    input  logic [lrd_pkg::S_TUSER_W-1:0] i_s_tuser,
    // Result stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // word_address[13:0], race[14], was_write[15], new_state[17:16]
    output logic [lrd_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int WA_W       = lrd_pkg::WORD_ADDR_W;
    localparam int AW         = $clog2(SHADOW_WORDS);
    localparam int TID_W      = $clog2(THREADS);
    localparam int OTH_W      = (TID_W > LOCK_SLOTS) ? TID_W : LOCK_SLOTS;
    localparam int ENT_W      = 2 + OTH_W;
    localparam bit MOD_ACTIVE = (SHADOW_WORDS < lrd_pkg::WORD_SPAN);
    localparam int RCP_SH     = 28;
    localparam int Q_W        = 11;
    localparam logic [24:0] RECIP = 25'((64'd1 << RCP_SH) / SHADOW_WORDS);
    localparam logic [WA_W-1:0] SMOD = MOD_ACTIVE ? WA_W'(SHADOW_WORDS) : WA_W'(1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_LOCK  = 6'b000100,
        ST_DIV1  = 6'b001000,
        ST_DIV2  = 6'b010000,
        ST_WORD  = 6'b100000
    } t_state;

    // Thread number modulo THREADS by repeated subtraction on four bits.
    function automatic logic [TID_W-1:0] tid_wrap(input logic [3:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 8; i++) begin
            if (t >= 9'(THREADS)) begin
                t = t - 9'(THREADS);
            end
        end
        return TID_W'(t);
    endfunction

    // Control and item registers.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [2:0]        r_op, n_op;
    logic [TID_W-1:0]  r_tid, n_tid;
    logic [2:0]        r_slot, n_slot;
    logic [WA_W-1:0]   r_raw, n_raw;
    logic [WA_W-1:0]   r_widx, n_widx;
    logic [1:0]        r_left, n_left;
    logic [Q_W-1:0]    r_q, n_q;

    // Output register.
    logic              r_m_tvalid, n_m_tvalid;
    logic [WA_W-1:0]   r_m_word, n_m_word;
    logic              r_m_race, n_m_race;
    logic              r_m_wr, n_m_wr;
    logic [1:0]        r_m_state, n_m_state;
    logic              r_m_last, n_m_last;

    // Shadow memory and its port.
    logic [ENT_W-1:0]  r_shadow [SHADOW_WORDS];
    logic [ENT_W-1:0]  r_sh_rdata;
    logic              sh_re, sh_we;
    logic [AW-1:0]     sh_raddr, sh_waddr;
    logic [ENT_W-1:0]  sh_wdata;

    // Lockset memory port.
    lrd_pkg::t_ls_ctrl ls_ctrl;
    logic [TID_W-1:0]  ls_addr;
    logic [LOCK_SLOTS-1:0] ls_wdata, ls_rdata, lock_bit;

    // Input fields.
    logic [2:0]        in_op;
    logic [3:0]        in_tid;
    logic [15:0]       in_addr;
    logic [3:0]        in_size, size_sat;
    logic [2:0]        in_slot;
    logic [4:0]        span_end;
    logic              accept;

    // Word index reduction.
    logic [38:0]       div_prod;
    logic [WA_W:0]     qs, rem, rem_c;
    logic [WA_W-1:0]   w_mod;

    // Word update.
    logic [1:0]        rd_st, new_st;
    logic [OTH_W-1:0]  rd_oth, new_oth, tid_ext, ls_ext;
    logic              is_wr, race, out_free;
    logic [WA_W-1:0]   raw_nx, widx_nx;
    logic [31:0]       widx_inc;

    // Field extraction from the input transfer.
    assign in_op   = i_s_tuser[2:0];
    assign in_tid  = i_s_tdata[3:0];
    assign in_addr = i_s_tdata[19:4];
    assign in_size = i_s_tdata[23:20];
    assign in_slot = i_s_tdata[26:24];
    assign accept  = i_s_tvalid && o_s_tready;

    // Size zero counts as one byte; sizes above the maximum are clipped.
    assign size_sat = (in_size == 4'd0) ? 4'd1 :
                      ((in_size > lrd_pkg::MAX_ACCESS_SIZE) ? lrd_pkg::MAX_ACCESS_SIZE
                                                             : in_size);
    assign span_end = 5'(in_addr[1:0]) + 5'(size_sat) - 5'd1;

    // Word index modulo SHADOW_WORDS: reciprocal estimate, then one correction.
    assign div_prod = 39'(r_raw) * 39'(RECIP);
    assign qs       = (WA_W + 1)'(25'(r_q) * 25'(SMOD));
    assign rem      = {1'b0, r_raw} - qs;
    assign rem_c    = (rem >= (WA_W + 1)'(SMOD)) ? (rem - (WA_W + 1)'(SMOD)) : rem;
    assign w_mod    = MOD_ACTIVE ? rem_c[WA_W-1:0] : r_raw;

    // Next word of a multi-word access, following the byte address wrap.
    assign raw_nx   = r_raw + WA_W'(1);
    assign widx_inc = 32'(r_widx) + 32'd1;
    assign widx_nx  = ((raw_nx == '0) || (widx_inc == 32'(SHADOW_WORDS))) ? '0
                                                                          : WA_W'(widx_inc);

    // Shadow entry update rules.
    assign rd_st   = r_sh_rdata[ENT_W-1 -: 2];
    assign rd_oth  = r_sh_rdata[OTH_W-1:0];
    assign tid_ext = OTH_W'(r_tid);
    assign ls_ext  = OTH_W'(ls_rdata);
    assign is_wr   = (r_op == lrd_pkg::OP_WRITE);

    always_comb begin
        new_st  = rd_st;
        new_oth = rd_oth;
        unique case (r_op)
            lrd_pkg::OP_INIT_VIRGIN: begin
                new_st  = lrd_pkg::WS_VIRGIN;
                new_oth = '0;
            end
            lrd_pkg::OP_INIT_OWNED: begin
                new_st  = lrd_pkg::WS_EXCL;
                new_oth = tid_ext;
            end
            default: begin
                unique case (rd_st)
                    lrd_pkg::WS_VIRGIN: begin
                        new_st  = lrd_pkg::WS_EXCL;
                        new_oth = tid_ext;
                    end
                    lrd_pkg::WS_EXCL: begin
                        if (rd_oth != tid_ext) begin
                            new_st  = is_wr ? lrd_pkg::WS_SHMOD : lrd_pkg::WS_SHAR;
                            new_oth = ls_ext;
                        end
                    end
                    lrd_pkg::WS_SHAR: begin
                        new_oth = rd_oth & ls_ext;
                        if (is_wr) begin
                            new_st = lrd_pkg::WS_SHMOD;
                        end
                    end
                    default: begin
                        new_oth = rd_oth & ls_ext;
                    end
                endcase
            end
        endcase
    end

    assign race     = (new_st == lrd_pkg::WS_SHMOD) && (new_oth == '0);
    assign out_free = !r_m_tvalid || i_m_tready;
    assign lock_bit = LOCK_SLOTS'(1) << r_slot;

    // Sequencer and next-value logic.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_tid      = r_tid;
        n_slot     = r_slot;
        n_raw      = r_raw;
        n_widx     = r_widx;
        n_left     = r_left;
        n_q        = r_q;
        n_m_tvalid = r_m_tvalid;
        n_m_word   = r_m_word;
        n_m_race   = r_m_race;
        n_m_wr     = r_m_wr;
        n_m_state  = r_m_state;
        n_m_last   = r_m_last;
        sh_re      = 1'b0;
        sh_raddr   = AW'(w_mod);
        sh_we      = 1'b0;
        sh_waddr   = AW'(r_widx);
        sh_wdata   = {new_st, new_oth};
        ls_ctrl    = '0;
        ls_addr    = r_tid;
        ls_wdata   = (r_op == lrd_pkg::OP_LOCK) ? (ls_rdata | lock_bit)
                                                : (ls_rdata & ~lock_bit);

        // The consumer takes the pending result.
        if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                sh_we    = 1'b1;
                sh_waddr = r_clr;
                sh_wdata = '0;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(SHADOW_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ls_addr = tid_wrap(in_tid);
                if (accept) begin
                    ls_ctrl.rd_en = 1'b1;
                    n_op   = in_op;
                    n_tid  = tid_wrap(in_tid);
                    n_slot = in_slot;
                    n_raw  = in_addr[15:2];
                    n_left = ((in_op == lrd_pkg::OP_READ) || (in_op == lrd_pkg::OP_WRITE))
                             ? span_end[3:2] : 2'd0;
                    if ((in_op == lrd_pkg::OP_LOCK) || (in_op == lrd_pkg::OP_UNLOCK)) begin
                        n_state = ST_LOCK;
                    end else if ((in_op == lrd_pkg::OP_READ) ||
                                 (in_op == lrd_pkg::OP_WRITE) ||
                                 (in_op == lrd_pkg::OP_INIT_VIRGIN) ||
                                 (in_op == lrd_pkg::OP_INIT_OWNED)) begin
                        n_state = ST_DIV1;
                    end
                end
            end
            ST_LOCK: begin
                // Slots beyond the configured count leave the lockset alone.
                ls_ctrl.wr_en = (32'(r_slot) < LOCK_SLOTS);
                n_state       = ST_IDLE;
            end
            ST_DIV1: begin
                n_q     = div_prod[RCP_SH +: Q_W];
                n_state = ST_DIV2;
            end
            ST_DIV2: begin
                sh_re   = 1'b1;
                n_widx  = w_mod;
                n_state = ST_WORD;
            end
            ST_WORD: begin
                // One word per cycle unless stalled: write this one back, read the next.
                if (out_free) begin
                    sh_we      = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_m_word   = r_widx;
                    n_m_race   = race;
                    n_m_wr     = race && is_wr;
                    n_m_state  = new_st;
                    n_m_last   = (r_left == 2'd0);
                    if (r_left == 2'd0) begin
                        n_state = ST_IDLE;
                    end else begin
                        sh_re    = 1'b1;
                        sh_raddr = AW'(widx_nx);
                        n_left   = r_left - 2'd1;
                        n_raw    = raw_nx;
                        n_widx   = widx_nx;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_tid     <= n_tid;
        r_slot    <= n_slot;
        r_raw     <= n_raw;
        r_widx    <= n_widx;
        r_left    <= n_left;
        r_q       <= n_q;
        r_m_word  <= n_m_word;
        r_m_race  <= n_m_race;
        r_m_wr    <= n_m_wr;
        r_m_state <= n_m_state;
        r_m_last  <= n_m_last;
    end

    // Shadow memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_shadow[sh_waddr] <= sh_wdata;
        end
        if (sh_re) begin
            r_sh_rdata <= r_shadow[sh_raddr];
        end
    end

    lrd_lockset_ram #(
        .THREADS    (THREADS),
        .LOCK_SLOTS (LOCK_SLOTS)
    ) u_lockset (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ls_ctrl),
        .i_addr    (ls_addr),
        .i_wr_data (ls_wdata),
        .o_rd_data (ls_rdata)
    );

    // Port drive.
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {6'd0, r_m_state, r_m_wr, r_m_race, r_m_word};
    assign o_m_tlast  = r_m_last;

    // No result leaves while the shadow memory is being cleared.
    `LRD_ASSERT_IMP(a_clear_quiet, r_state == ST_CLEAR, !r_m_tvalid)
    // Writing one word and reading the next never hit the same entry.
    `LRD_ASSERT_IMP(a_rmw_distinct, sh_we && sh_re, sh_waddr != sh_raddr)
    // A race is only reported for a shared-modified word.
    `LRD_ASSERT_IMP(a_race_state, r_m_tvalid && r_m_race, r_m_state == lrd_pkg::WS_SHMOD)
    // The write flag only accompanies a race.
    `LRD_ASSERT_IMP(a_write_flag, r_m_tvalid && r_m_wr, r_m_race)
    // A defined operation closes the input until its work is done.
    `LRD_ASSERT_NXT(a_one_item, accept && (in_op[2:1] != 2'b11), !o_s_tready)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Lockset race detector testbench
// Drives read, write, lock, unlock and init items into the detector and checks
// every per-word result against a shadow-store prediction held in a scoreboard
// class. A short directed sequence is followed by random critical sections,
// unlocked accesses, init items and noise, with random stalls on both streams.
// ============================================================================
module tb_top;

    // Codes the block decodes as no operation.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS   = 285;
    localparam int CALM_ITEMS     = 50;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic [15:0] POOL_BASE = 16'h1000;

    // One expected result for one shadow word.
    typedef struct packed {
        logic [lrd_pkg::WORD_ADDR_W-1:0] word_idx;
        logic                            race;
        logic                            was_write;
        logic [1:0]                      state;
        logic                            last;
    } t_word_outcome;

    // Shadow store prediction and the queue of word results still due.
    class lockset_scoreboard;
        logic [1:0]    word_state [lrd_pkg::WORD_SPAN];
        logic [7:0]    word_tag [lrd_pkg::WORD_SPAN];
        logic [7:0]    held_locks [16];
        t_word_outcome outcomes_due [$];
        int            errors;
        int            results_seen;
        int            races_seen;

        function new();
            foreach (word_state[i]) begin
                word_state[i] = lrd_pkg::WS_VIRGIN;
                word_tag[i]   = 8'h00;
            end
            foreach (held_locks[i]) held_locks[i] = 8'h00;
            errors       = 0;
            results_seen = 0;
            races_seen   = 0;
        endfunction

        function int outstanding();
            return outcomes_due.size();
        endfunction

        // Update the prediction for one accepted input transfer.
        function void note_item(logic [2:0] op, logic [3:0] tid, logic [15:0] addr,
                                logic [3:0] size, logic [2:0] slot);
            t_word_outcome res;
            logic [15:0]   byte_k;
            logic [13:0]   w;
            logic [1:0]    st;
            logic [7:0]    locks;
            logic          is_wr;
            int            span;
            int            nwords;
            int            k;
            case (op)
                lrd_pkg::OP_LOCK: held_locks[tid][slot] = 1'b1;
                lrd_pkg::OP_UNLOCK: held_locks[tid][slot] = 1'b0;
                lrd_pkg::OP_INIT_VIRGIN, lrd_pkg::OP_INIT_OWNED: begin
                    w = addr[15:2];
                    word_state[w] = (op == lrd_pkg::OP_INIT_OWNED) ? lrd_pkg::WS_EXCL
                                                                   : lrd_pkg::WS_VIRGIN;
                    word_tag[w]   = (op == lrd_pkg::OP_INIT_OWNED) ? {4'h0, tid} : 8'h00;
                    res.word_idx  = w;
                    res.race      = 1'b0;
                    res.was_write = 1'b0;
                    res.state     = word_state[w];
                    res.last      = 1'b1;
                    outcomes_due.push_back(res);
                end
                lrd_pkg::OP_READ, lrd_pkg::OP_WRITE: begin
                    is_wr = (op == lrd_pkg::OP_WRITE);
                    locks = held_locks[tid];
                    // Size zero counts as one byte; large sizes are clipped.
                    if (size == 4'd0) span = 1;
                    else if (size > lrd_pkg::MAX_ACCESS_SIZE) span = int'(lrd_pkg::MAX_ACCESS_SIZE);
                    else span = int'(size);
                    // The span is counted without wrap; the addresses wrap.
                    nwords = ((int'(addr) + span - 1) >> 2) - (int'(addr) >> 2) + 1;
                    for (k = 0; k < nwords; k++) begin
                        byte_k = addr + 16'(4 * k);
                        w  = byte_k[15:2];
                        st = word_state[w];
                        case (st)
                            lrd_pkg::WS_VIRGIN: begin
                                st = lrd_pkg::WS_EXCL;
                                word_tag[w] = {4'h0, tid};
                            end
                            lrd_pkg::WS_EXCL: begin
                                if (word_tag[w] != {4'h0, tid}) begin
                                    st = is_wr ? lrd_pkg::WS_SHMOD : lrd_pkg::WS_SHAR;
                                    word_tag[w] = locks;
                                end
                            end
                            lrd_pkg::WS_SHAR: begin
                                word_tag[w] = word_tag[w] & locks;
                                if (is_wr) st = lrd_pkg::WS_SHMOD;
                            end
                            default: word_tag[w] = word_tag[w] & locks;
                        endcase
                        word_state[w] = st;
                        res.word_idx  = w;
                        res.race      = (st == lrd_pkg::WS_SHMOD) && (word_tag[w] == 8'h00);
                        res.was_write = res.race & is_wr;
                        res.state     = st;
                        res.last      = (k == nwords - 1);
                        outcomes_due.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        // Compare one accepted result transfer with the oldest expectation.
        function void check_word(logic [lrd_pkg::M_TDATA_W-1:0] data, logic tlast);
            t_word_outcome got;
            t_word_outcome want;
            got.word_idx  = data[13:0];
            got.race      = data[14];
            got.was_write = data[15];
            got.state     = data[17:16];
            got.last      = tlast;
            results_seen++;
            if (got.race) races_seen++;
            if (outcomes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual word %0h state %0d",
                         $time, got.word_idx, got.state);
                return;
            end
            want = outcomes_due.pop_front();
            compare_field("word_address", int'(want.word_idx), int'(got.word_idx));
            compare_field("race", int'(want.race), int'(got.race));
            compare_field("was_write", int'(want.was_write), int'(got.was_write));
            compare_field("new_state", int'(want.state), int'(got.state));
            compare_field("last", int'(want.last), int'(got.last));
        endfunction
    endclass

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic [lrd_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [lrd_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tready = 1'b0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [lrd_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic                           o_m_tlast;

    lockset_race_detector DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    lockset_scoreboard board;
    bit idling_on = 1'b1;
    int items_sent = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Send one item and wait for its transfer, with an optional idle burst first.
    task automatic send_item(input logic [2:0] op, input logic [3:0] tid,
                             input logic [15:0] addr, input logic [3:0] size,
                             input logic [2:0] slot);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, slot, size, addr, tid};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_item(op, tid, addr, size, slot);
        if (op != OP_RSVD6 && op != OP_RSVD7) items_sent++;
    endtask

    // Mostly a small window of shared words, sometimes the top of memory or anywhere.
    function automatic logic [15:0] pick_address();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 16) return POOL_BASE + 16'($urandom_range(0, 47));
        if (roll == 16) return 16'hFFF0 + 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    // Read or write by one thread, mostly at a random place in the shared window.
    task automatic send_access(input logic [3:0] tid);
        logic [3:0] size;
        size = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 10))
                                          : 4'($urandom_range(0, 15));
        send_item($urandom_range(0, 1) ? lrd_pkg::OP_WRITE : lrd_pkg::OP_READ, tid,
                  pick_address(), size, 3'($urandom_range(0, 7)));
    endtask

    // Result side: check each transfer and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tready && o_m_tvalid) begin
            board.check_word(o_m_tdata, o_m_tlast);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left <= int'($urandom_range(0, 3));
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: the clearing pass after reset is the longest legal quiet stretch.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (m_tready && o_m_tvalid)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [3:0] tid;
        logic [2:0] slot;
        int         target;
        int         mode;
        int         n;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ownership, sharing, races on read and write, lock corner cases.
        send_item(lrd_pkg::OP_WRITE, 4'd0, 16'h0000, 4'd4, 3'd0);
        send_item(lrd_pkg::OP_READ, 4'd0, 16'h0000, 4'd4, 3'd7);
        send_item(lrd_pkg::OP_LOCK, 4'd1, 16'hFFFF, 4'd15, 3'd0);
        send_item(lrd_pkg::OP_LOCK, 4'd1, 16'h0000, 4'd0, 3'd0);     // already held
        send_item(lrd_pkg::OP_READ, 4'd1, 16'h0000, 4'd4, 3'd0);     // becomes shared
        send_item(lrd_pkg::OP_LOCK, 4'd2, 16'h0000, 4'd1, 3'd7);
        send_item(lrd_pkg::OP_WRITE, 4'd2, 16'h0001, 4'd1, 3'd0);    // write race
        send_item(lrd_pkg::OP_READ, 4'd3, 16'h0002, 4'd1, 3'd0);     // read race
        send_item(lrd_pkg::OP_UNLOCK, 4'd1, 16'h0000, 4'd0, 3'd3);   // not held
        send_item(lrd_pkg::OP_UNLOCK, 4'd1, 16'h0000, 4'd0, 3'd0);
        send_item(lrd_pkg::OP_WRITE, 4'd15, 16'h0100, 4'd0, 3'd0);   // size zero
        send_item(lrd_pkg::OP_READ, 4'd15, 16'h0101, 4'd15, 3'd0);   // size clipped
        send_item(lrd_pkg::OP_WRITE, 4'd4, 16'hFFFF, 4'd10, 3'd0);   // wraps to zero
        send_item(lrd_pkg::OP_WRITE, 4'd5, 16'hFFFE, 4'd2, 3'd0);
        send_item(lrd_pkg::OP_INIT_VIRGIN, 4'd0, 16'hFFFF, 4'd0, 3'd0);
        send_item(lrd_pkg::OP_INIT_OWNED, 4'd9, 16'h0003, 4'd0, 3'd0);
        send_item(lrd_pkg::OP_READ, 4'd9, 16'h0000, 4'd4, 3'd0);
        send_item(OP_RSVD6, 4'd7, 16'hAAAA, 4'd5, 3'd5);
        send_item(OP_RSVD7, 4'd8, 16'h5555, 4'd10, 3'd2);
        send_item(lrd_pkg::OP_LOCK, 4'd6, 16'h0000, 4'd0, 3'd1);
        send_item(lrd_pkg::OP_LOCK, 4'd7, 16'h0000, 4'd0, 3'd1);
        send_item(lrd_pkg::OP_WRITE, 4'd6, 16'h0200, 4'd4, 3'd0);
        send_item(lrd_pkg::OP_READ, 4'd7, 16'h0200, 4'd4, 3'd0);     // common lock
        send_item(lrd_pkg::OP_WRITE, 4'd6, 16'h0200, 4'd4, 3'd0);    // lock still common
        send_item(lrd_pkg::OP_WRITE, 4'd1, 16'h0103, 4'd8, 3'd0);

        // Random: mostly critical sections over a shared window, then noise.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            idling_on = (items_sent < target - CALM_ITEMS);
            tid  = 4'($urandom_range(0, 15));
            slot = 3'($urandom_range(0, 7));
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                send_item(lrd_pkg::OP_LOCK, tid, 16'($urandom), 4'($urandom_range(0, 15)),
                          slot);
                n = $urandom_range(1, 4);
                repeat (n) send_access(tid);
                // Now and then the lock stays held or a different slot is released.
                if ($urandom_range(0, 4) != 0) begin
                    send_item(lrd_pkg::OP_UNLOCK, tid, 16'($urandom),
                              4'($urandom_range(0, 15)),
                              ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : slot);
                end
            end else if (mode < 8) begin
                send_access(tid);
            end else if (mode == 8) begin
                send_item($urandom_range(0, 1) ? lrd_pkg::OP_INIT_OWNED
                                               : lrd_pkg::OP_INIT_VIRGIN,
                          tid, pick_address(), 4'($urandom_range(0, 15)), slot);
            end else begin
                send_item(3'($urandom_range(0, 7)), tid, 16'($urandom),
                          4'($urandom_range(0, 15)), slot);
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow a short quiet tail.
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items with reads, writes, locks, unlocks and inits;",
                 items_sent);
        $display("checked %0d word results, %0d of them flagged as races.",
                 board.results_seen, board.races_seen);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/lrd_pkg.sv
rtl/lrd_lockset_ram.sv
rtl/lockset_race_detector.sv
verif/tb_top.sv
